// ----- design/qsu_pkg.sv -----
package qsu_pkg;

  // Decoder modes
  typedef enum logic [1:0] {
    MODE_AWAIT_OPEN = 2'd0,
    MODE_BODY       = 2'd1,
    MODE_ESCAPE     = 2'd2,
    MODE_HEX_LOW    = 2'd3
  } mode_t;

  // Character codes
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_APOS      = 8'h27;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

  // One input transaction
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] byte_val;
    logic       byte_valid;
    logic       text_end;
  } res_t;

  // Hex digit value; anything that is not a digit counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
        d = c - CHAR_DIGIT_0;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
        d = c - CHAR_LOWER_A + 8'd10;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
        d = c - CHAR_UPPER_A + 8'd10;
      end
      hex_value = d[3:0];
    end
  endfunction

endpackage

// ----- design/quoted_string_unescaper_unit.sv -----
// An input transaction passes through the input register and then the result register.
// Throughput: one byte per cycle; the decoder steps once per cycle when the
//   result register is free or drains in the same cycle.
// Items that give no result (opening quote, backslash, first hex digit) are still consumed like any other byte.
// Reset: synchronous, active low; empties both registers and returns the decoder
//   to the awaiting-opening-quote mode with a zero held digit.
module quoted_string_unescaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] byte_valid
  output logic       out_tlast   // text_end
);

  qsu_pkg::item_t in_item;
  qsu_pkg::item_t item;
  logic           item_valid;
  logic           item_take;
  qsu_pkg::res_t  res;

  assign in_item.byte_val = in_tdata;
  assign in_item.last     = in_tlast;

  qsu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  qsu_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = res.byte_val;
  assign out_tuser = res.byte_valid;
  assign out_tlast = res.text_end;

endmodule

// ----- design/qsu_in_reg.sv -----
module qsu_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qsu_pkg::item_t in_item,
  output logic          item_valid,
  input  logic          item_take,
  output qsu_pkg::item_t item
);

  logic           valid_r;
  qsu_pkg::item_t item_r;

  // Load a new item when the register is empty or drains this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- design/qsu_core.sv -----
module qsu_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_take,
  input  qsu_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output qsu_pkg::res_t  res
);

  qsu_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]     nib_r, nib_nxt;
  logic           out_valid_r;
  qsu_pkg::res_t  res_r;
  logic           emit;
  qsu_pkg::res_t  res_nxt;
  logic           slot_free;

  // Step the decoder whenever the result register can take a result
  assign slot_free = !out_valid_r || res_ready;
  assign item_take = item_valid && slot_free;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // Next mode and pending high digit
  always_comb begin
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    if (item.last) begin
      mode_nxt = qsu_pkg::MODE_AWAIT_OPEN;
      nib_nxt  = 4'd0;
    end else begin
      unique case (mode_r)
        qsu_pkg::MODE_AWAIT_OPEN: mode_nxt = qsu_pkg::MODE_BODY;
        qsu_pkg::MODE_BODY: begin
          if (item.byte_val == qsu_pkg::CHAR_BACKSLASH) begin
            mode_nxt = qsu_pkg::MODE_ESCAPE;
          end
        end
        qsu_pkg::MODE_ESCAPE: begin
          case (item.byte_val)
            qsu_pkg::CHAR_LOWER_T, qsu_pkg::CHAR_LOWER_N, qsu_pkg::CHAR_LOWER_R,
            qsu_pkg::CHAR_DQUOTE, qsu_pkg::CHAR_APOS, qsu_pkg::CHAR_BACKSLASH:
              mode_nxt = qsu_pkg::MODE_BODY;
            default: begin
              mode_nxt = qsu_pkg::MODE_HEX_LOW;
              nib_nxt  = qsu_pkg::hex_value(item.byte_val);
            end
          endcase
        end
        qsu_pkg::MODE_HEX_LOW: begin
          mode_nxt = qsu_pkg::MODE_BODY;
          nib_nxt  = 4'd0;
        end
        default: mode_nxt = qsu_pkg::MODE_AWAIT_OPEN;
      endcase
    end
  end

  // Result of the current item
  always_comb begin
    emit    = 1'b0;
    res_nxt = '0;
    if (item.last) begin
      emit             = 1'b1;
      res_nxt.text_end = 1'b1;
    end else begin
      unique case (mode_r)
        qsu_pkg::MODE_AWAIT_OPEN: emit = 1'b0;
        qsu_pkg::MODE_BODY: begin
          emit             = (item.byte_val != qsu_pkg::CHAR_BACKSLASH);
          res_nxt.byte_val = item.byte_val;
        end
        qsu_pkg::MODE_ESCAPE: begin
          emit = 1'b1;
          case (item.byte_val)
            qsu_pkg::CHAR_LOWER_T: res_nxt.byte_val = qsu_pkg::CHAR_TAB;
            qsu_pkg::CHAR_LOWER_N: res_nxt.byte_val = qsu_pkg::CHAR_NEWLINE;
            qsu_pkg::CHAR_LOWER_R: res_nxt.byte_val = qsu_pkg::CHAR_CR;
            qsu_pkg::CHAR_DQUOTE, qsu_pkg::CHAR_APOS, qsu_pkg::CHAR_BACKSLASH:
              res_nxt.byte_val = item.byte_val;
            default: emit = 1'b0;
          endcase
        end
        qsu_pkg::MODE_HEX_LOW: begin
          emit             = 1'b1;
          res_nxt.byte_val = {nib_r, qsu_pkg::hex_value(item.byte_val)};
        end
        default: emit = 1'b0;
      endcase
      res_nxt.byte_valid = emit;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qsu_pkg::MODE_AWAIT_OPEN;
      nib_r  <= 4'd0;
    end else if (item_take) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
    end
  end

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= item_valid && emit;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res_r <= res_nxt;
    end
  end

  // Closing item always returns the decoder to the idle mode
  a_end_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.last) |=> (mode_r == qsu_pkg::MODE_AWAIT_OPEN && nib_r == 4'd0))
    else $error("decoder not idle after closing item");

  // A held high digit only exists while waiting for the low digit
  a_nibble_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (nib_r != 4'd0) |-> (mode_r == qsu_pkg::MODE_HEX_LOW))
    else $error("high digit held outside hex mode");

  // A result is either a byte or the end marker, never both or neither
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.byte_valid != res_r.text_end))
    else $error("malformed result");

  // End marker carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.text_end) |-> (res_r.byte_val == 8'd0))
    else $error("end marker with nonzero byte");

endmodule
